// File: rtl/core/horizontal_motion_blur_top_defines.svh
// Assertion macros used by the blur top.
`ifndef HORIZONTAL_MOTION_BLUR_TOP_DEFINES_SVH
`define HORIZONTAL_MOTION_BLUR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked while reset is released.
`define HMB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define HMB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMB_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define HMB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/hmb_pkg.sv
package hmb_pkg;

    localparam int WINDOW    = 50;
    localparam int CNT_W     = 6;
    localparam int NCH       = 3;
    localparam int HALF_W    = 7;
    localparam int STEP_W    = 6;
    localparam int DIV_STEPS = 7;

    // Channels packed as {red, green, blue}.
    typedef logic [NCH-1:0][7:0]        t_pix;
    typedef logic [NCH-1:0][HALF_W-1:0] t_half;

    typedef struct packed {
        logic load;
        logic shift;
        logic div_init;
        logic div_step;
        logic q_shift;
    } t_cell_ctrl;

    // floor(c / (2 * WINDOW)) for one 8-bit channel, found by counting the
    // multiples of 2 * WINDOW that the channel reaches.
    function automatic logic [HALF_W-1:0] f_term(input logic [7:0] c);
        logic [HALF_W-1:0] t;
        t = '0;
        for (int k = 1; k <= 255 / (2 * WINDOW); k++) begin
            if (int'(c) >= k * 2 * WINDOW) begin
                t = HALF_W'(k);
            end
        end
        return t;
    endfunction

endpackage

// File: rtl/core/horizontal_motion_blur_top.sv
// Row-wise motion blur on RGB pixels. Each output is half the pixel plus a
// share of the later pixels of its row; outputs trail the input by 49
// pixels, and a pixel marked as row end flushes every waiting pixel. A pixel
// that does not end a row leaves the block idle, ready for the next one
// unless the output stalls. A row end holds the input while the flush runs:
// for each waiting pixel a set-up state, the per-cell divider steps, the
// steps that move the quotient chain into the accumulator and an output
// state, plus any output stall.
`include "horizontal_motion_blur_top_defines.svh"

module horizontal_motion_blur_top import hmb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_red,
    input  logic [7:0] i_in_green,
    input  logic [7:0] i_in_blue,
    input  logic       i_row_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic       o_row_done
);

    typedef enum logic [2:0] {S_IDLE, S_INIT, S_DIV, S_SUM, S_EMIT} t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_step;
    t_half             r_sums;
    t_pix              r_acc;
    logic              r_out_valid;
    t_pix              r_out;
    logic              r_done;
    logic              n_out_valid;

    t_pix       cell_px [WINDOW-1];
    t_half      cell_q  [WINDOW-1];
    t_cell_ctrl ctrl;
    t_pix       in_px;
    t_half      n_rest;
    t_pix       full_val;
    t_pix       flush_val;
    logic       out_free;
    logic       accept;
    logic       full;

    assign in_px    = {i_in_red, i_in_green, i_in_blue};
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept   = i_in_valid && !o_in_stall;
    assign full     = (r_cnt == CNT_W'(WINDOW - 1));

    // Control for the cell row.
    always_comb begin
        ctrl.load     = (r_state == S_IDLE) && accept && !full;
        ctrl.shift    = ((r_state == S_IDLE) && accept && full) ||
                        ((r_state == S_EMIT) && out_free);
        ctrl.div_init = (r_state == S_INIT);
        ctrl.div_step = (r_state == S_DIV);
        ctrl.q_shift  = (r_state == S_SUM);
    end

    // The output register is loaded by a full-window or flush result and
    // otherwise holds until its transfer.
    assign n_out_valid = ((r_state == S_IDLE) && accept && full) ||
                         ((r_state == S_EMIT) && out_free) ||
                         (r_out_valid && i_out_stall);

    // Row of cells, one per waiting pixel; the last one is fed the incoming pixel.
    for (genvar i = 0; i < WINDOW - 1; i++) begin : g_cell
        t_pix  nbr_px;
        t_half nbr_q;
        if (i == WINDOW - 2) begin : g_last
            assign nbr_px = in_px;
            assign nbr_q  = '0;
        end else begin : g_mid
            assign nbr_px = cell_px[i+1];
            assign nbr_q  = cell_q[i+1];
        end
        hmb_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (ctrl),
            .i_load    (r_cnt == CNT_W'(i)),
            .i_load_px (in_px),
            .i_nbr_px  (nbr_px),
            .i_nbr_q   (nbr_q),
            .i_div     (r_cnt),
            .o_px      (cell_px[i]),
            .o_q       (cell_q[i])
        );
    end

    // Full-window and flush result values.
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_rest[c]    = r_sums[c] + f_term(in_px[c]) - f_term(cell_px[0][c]);
            full_val[c]  = {1'b0, cell_px[0][c][7:1]} + {1'b0, n_rest[c]};
            flush_val[c] = {1'b0, cell_px[0][c][7:1]} + r_acc[c];
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_step      <= '0;
            r_sums      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (full) begin
                            r_sums      <= n_rest;
                            r_out       <= full_val;
                            r_done      <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                            for (int c = 0; c < NCH; c++) begin
                                r_sums[c] <= r_sums[c] + f_term(in_px[c]);
                            end
                        end
                        if (i_row_end) begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_step  <= STEP_W'(DIV_STEPS - 1);
                    r_acc   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        if (r_cnt > CNT_W'(1)) begin
                            r_step  <= STEP_W'(r_cnt - CNT_W'(2));
                            r_state <= S_SUM;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_SUM: begin
                    for (int c = 0; c < NCH; c++) begin
                        r_acc[c] <= r_acc[c] + {1'b0, cell_q[1][c]};
                    end
                    if (r_step == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out       <= flush_val;
                        r_done      <= (r_cnt == CNT_W'(1));
                        r_cnt       <= r_cnt - 1'b1;
                        if (r_cnt == CNT_W'(1)) begin
                            r_sums  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_INIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out[2];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[0];
    assign o_row_done  = r_done;

    // The waiting count never reaches a full window between transfers.
    `HMB_ASSERT_RST(a_cnt_bound, i_clk, i_rst_n, (r_cnt <= CNT_W'(WINDOW - 1)), "count overflow")
    // A flush always has at least one waiting pixel.
    `HMB_ASSERT_RST(a_flush_nonempty, i_clk, i_rst_n, ((r_state != S_IDLE) |-> (r_cnt != '0)), "empty flush")
    // Input is held off for the whole flush.
    `HMB_ASSERT_ALWAYS(a_busy_stall, i_clk, ((r_state != S_IDLE) |-> o_in_stall), "input taken while busy")
    // The last flushed pixel returns the block to idle with a marked result.
    `HMB_ASSERT_RST(a_flush_end, i_clk, i_rst_n, (((r_state == S_EMIT) && out_free && (r_cnt == CNT_W'(1))) |=> ((r_state == S_IDLE) && o_row_done && o_out_valid)), "bad flush end")

endmodule

// File: rtl/core/hmb_cell.sv
module hmb_cell import hmb_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic             i_load,
    input  t_pix             i_load_px,
    input  t_pix             i_nbr_px,
    input  t_half            i_nbr_q,
    input  logic [CNT_W-1:0] i_div,
    output t_pix             o_px,
    output t_half            o_q
);

    t_pix  r_px;
    t_half r_rem;
    t_half r_quo;
    t_half n_rem;
    t_half n_quo;

    // One restoring division step per channel: half the channel over i_div.
    always_comb begin
        logic [HALF_W-1:0] t;
        for (int c = 0; c < NCH; c++) begin
            t = {r_rem[c][HALF_W-2:0], r_quo[c][HALF_W-1]};
            if (t >= HALF_W'(i_div)) begin
                n_rem[c] = t - HALF_W'(i_div);
                n_quo[c] = {r_quo[c][HALF_W-2:0], 1'b1};
            end else begin
                n_rem[c] = t;
                n_quo[c] = {r_quo[c][HALF_W-2:0], 1'b0};
            end
        end
    end

    // Pixel holder, divider and quotient chain stage.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_px <= i_nbr_px;
        end else if (i_ctrl.load && i_load) begin
            r_px <= i_load_px;
        end
        if (i_ctrl.div_init) begin
            r_rem <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_quo[c] <= r_px[c][7:1];
            end
        end else if (i_ctrl.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end else if (i_ctrl.q_shift) begin
            r_quo <= i_nbr_q;
        end
    end

    assign o_px = r_px;
    assign o_q  = r_quo;

endmodule

// File: sim/horizontal_motion_blur_top_test.sv
`timescale 1ns / 1ps

module horizontal_motion_blur_top_test;
    import hmb_pkg::*;

    // One input pixel as it is offered to the block.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel_in;

    // One blurred pixel as the block returns it.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       done;
    } t_pixel_out;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_red;
    logic [7:0] i_in_green;
    logic [7:0] i_in_blue;
    logic       i_row_end;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_red;
    logic [7:0] o_out_green;
    logic [7:0] o_out_blue;
    logic       o_row_done;

    horizontal_motion_blur_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_red   (i_in_red),
        .i_in_green (i_in_green),
        .i_in_blue  (i_in_blue),
        .i_row_end  (i_row_end),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_red  (o_out_red),
        .o_out_green(o_out_green),
        .o_out_blue (o_out_blue),
        .o_row_done (o_row_done)
    );

    t_pixel_in  pixels_to_send[$];
    t_pixel_out blurred_expected[$];
    int         error_count;
    int         send_idle_pct;
    int         stall_pct;
    bit         stimulus_done;
    bit         in_taken;

    // Model state: waiting pixels, oldest first.
    t_pix       row_window[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Work out the blurred pixels that one accepted input pixel releases.
    task automatic blur_predict(input t_pixel_in p);
        t_pix       px;
        t_pixel_out r;
        int         n;
        int         acc [3];
        px[2] = p.red;
        px[1] = p.green;
        px[0] = p.blue;
        row_window.push_back(px);
        if (row_window.size() == WINDOW) begin
            // Full window: oldest pixel leaves with the fixed divisor.
            for (int c = 0; c < 3; c++) begin
                acc[c] = row_window[0][c] / 2;
                for (int u = 1; u < WINDOW; u++)
                    acc[c] += row_window[u][c] / (2 * WINDOW);
            end
            r = '{acc[2][7:0], acc[1][7:0], acc[0][7:0], 1'b0};
            blurred_expected.push_back(r);
            void'(row_window.pop_front());
        end
        if (p.last) begin
            // Row end: flush everything with the remaining-count divisor.
            n = row_window.size();
            for (int k = 0; k < n; k++) begin
                for (int c = 0; c < 3; c++) begin
                    acc[c] = row_window[k][c] / 2;
                    for (int u = k + 1; u < n; u++)
                        acc[c] += row_window[u][c] / (2 * (n - k));
                end
                r = '{acc[2][7:0], acc[1][7:0], acc[0][7:0], k == n - 1};
                blurred_expected.push_back(r);
            end
            row_window.delete();
        end
    endtask

    // Driver: offers queued pixels, changing inputs at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pixels_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_pixel_in p;
                p = pixels_to_send.pop_front();
                i_in_valid <= 1'b1;
                i_in_red   <= p.red;
                i_in_green <= p.green;
                i_in_blue  <= p.blue;
                i_row_end  <= p.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                blur_predict('{i_in_red, i_in_green, i_in_blue, i_row_end});
            if (o_out_valid && !i_out_stall) begin
                if (blurred_expected.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    t_pixel_out e;
                    e = blurred_expected.pop_front();
                    if (o_out_red !== e.red) report_mismatch("red", o_out_red, e.red);
                    if (o_out_green !== e.green)
                        report_mismatch("green", o_out_green, e.green);
                    if (o_out_blue !== e.blue) report_mismatch("blue", o_out_blue, e.blue);
                    if (o_row_done !== e.done)
                        report_mismatch("row_done", o_row_done, e.done);
                end
            end
        end
    end

    function automatic t_pixel_in random_pixel(input bit last);
        t_pixel_in p;
        p.red   = $urandom_range(255);
        p.green = $urandom_range(255);
        p.blue  = $urandom_range(255);
        p.last  = last;
        return p;
    endfunction

    // Queue a row of the given length with random content.
    task automatic queue_row(input int len);
        for (int i = 0; i < len; i++)
            pixels_to_send.push_back(random_pixel(i == len - 1));
    endtask

    task automatic drain_queue();
        while (pixels_to_send.size() > 0 || i_in_valid) @(posedge i_clk);
    endtask

    initial begin
        int lens[] = '{1, 2, 3, 49, 50, 51, 60, 5, 13, 100};
        error_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        stimulus_done = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_red    = '0;
        i_in_green  = '0;
        i_in_blue   = '0;
        i_row_end   = 1'b0;
        i_out_stall = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme values in a three-pixel row and two single-pixel rows, then a two-pixel row.
        pixels_to_send.push_back('{8'd255, 8'd255, 8'd255, 1'b0});
        pixels_to_send.push_back('{8'd255, 8'd0, 8'd255, 1'b0});
        pixels_to_send.push_back('{8'd0, 8'd255, 8'd0, 1'b1});
        pixels_to_send.push_back('{8'd255, 8'd255, 8'd255, 1'b1});
        pixels_to_send.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
        pixels_to_send.push_back('{8'd99, 8'd100, 8'd199, 1'b0});
        pixels_to_send.push_back('{8'd200, 8'd1, 8'd254, 1'b1});
        drain_queue();

        // Pause until every blurred pixel of the directed rows is out.
        while (blurred_expected.size() > 0) @(posedge i_clk);

        // Random rows across the idle and stall phases; short lengths, or lengths from a list around the window edge.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 68 : 0;
            stall_pct     = (ph == 2 || ph == 3) ? 68 : 0;
            if (ph == 3) begin
                send_idle_pct = 6;
                stall_pct     = 6;
            end
            for (int r = 0; r < 4; r++) begin
                if ($urandom_range(3) == 0)
                    queue_row(lens[$urandom_range(lens.size() - 1)]);
                else
                    queue_row($urandom_range(1, 12));
            end
            drain_queue();
        end
        // One long row crossing the full-window path many times.
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_row(70);
        drain_queue();
        stimulus_done = 1;

        while (blurred_expected.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && blurred_expected.size() == 0 && row_window.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
